// ===== rtl/core/offset_limited_drift_rate_update_defines.svh =====
// ----------------------------------------------------------------------------
// offset limited drift rate update: assertion macros
// shared property shorthands, sampled on clk and masked while rst_n is low
// ----------------------------------------------------------------------------
`ifndef OFFSET_LIMITED_DRIFT_RATE_UPDATE_DEFINES_SVH
`define OFFSET_LIMITED_DRIFT_RATE_UPDATE_DEFINES_SVH

// consequent holds in the same cycle
`define OLDRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define OLDRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/oldru_pkg.sv =====
// ----------------------------------------------------------------------------
// oldru_pkg
// widths, register indexes, reset values and constants of the drift update
// ----------------------------------------------------------------------------
package oldru_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int DRIFT_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam int OFFSET_W   = 40;
  localparam int ADJ_W      = 20;
  localparam int INTERVAL_W = 40;
  localparam int INIT_W     = 21;
  localparam int LOWER_W    = 22;
  localparam int UPPER_W    = 21;
  localparam int STEP_W     = 21;
  localparam int OUT_W      = 23;
  localparam int SCALE_W    = 30;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ADJUST      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_INTERVAL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DRIFT   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LOWER    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_UPPER    = CFG_IDX_W'(5);

  localparam logic        [OFFSET_W-1:0]   RST_MAX_OFFSET      = 40'd1000000;
  localparam logic        [ADJ_W-1:0]      RST_MAX_ADJUST      = 20'd1000;
  localparam logic        [INTERVAL_W-1:0] RST_CHANGE_INTERVAL = 40'd1000000000;
  localparam logic signed [INIT_W-1:0]     RST_INITIAL_DRIFT   = 21'sd0;
  localparam logic signed [LOWER_W-1:0]    RST_CHANGE_LOWER    = -22'sd100000;
  localparam logic        [UPPER_W-1:0]    RST_CHANGE_UPPER    = 21'd100000;

  // ppb per unit
  localparam logic [SCALE_W-1:0] PPB_SCALE = 30'd1000000000;

  localparam logic signed [OUT_W-1:0] OUT_LIMIT = 23'sd4000000;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/oldru_in_if.sv =====
// ----------------------------------------------------------------------------
// oldru_in_if
// change tick channel: clock offset and random drift step per beat
// ----------------------------------------------------------------------------
interface oldru_in_if #(
  parameter int TIME_BITS = oldru_pkg::TIME_BITS_DEF
) ();

  logic                                   valid;
  logic                                   ready;
  logic signed [TIME_BITS-1:0]            cur_offset;
  logic signed [oldru_pkg::STEP_W-1:0]    random_step;

  modport source (output valid, output cur_offset, output random_step, input ready);
  modport sink   (input valid, input cur_offset, input random_step, output ready);

endinterface

// ===== rtl/core/oldru_out_if.sv =====
// ----------------------------------------------------------------------------
// oldru_out_if
// result channel: new drift rate and corrective flag per beat
// ----------------------------------------------------------------------------
interface oldru_out_if ();

  logic                                valid;
  logic                                ready;
  logic signed [oldru_pkg::OUT_W-1:0]  new_drift;
  logic                                corrected;

  modport source (output valid, output new_drift, output corrected, input ready);
  modport sink   (input valid, input new_drift, input corrected, output ready);

endinterface

// ===== rtl/core/offset_limited_drift_rate_update.sv =====
// ----------------------------------------------------------------------------
// offset_limited_drift_rate_update
// One input beat is one change tick (cur_offset, random_step); one output
// beat (new_drift, corrected) follows for each. The user must write the
// configuration through cfg_we/cfg_idx/cfg_wdata only while no tick is
// in flight; the block does not enforce it. in_ch.ready is high only while
// no tick is being worked on. A tick that needs no product (zero drift,
// drift moving away, or offset past the limit) goes through ST_PREP,
// ST_FIN and ST_OUT. Otherwise one shared shift-add multiplier forms drift
// squared, times change_interval, max_adjust times 1e9, and that times the
// headroom, two bits per cycle; the length of the full path is set by the
// multiplier bit counts (drift magnitude, change_interval, max_adjust,
// headroom). The result waits in an output register; the next tick is
// accepted while it waits, and a stalled receiver holds only the final
// write of that next tick. Synchronous reset restores the register reset
// values, clears the accumulated change and empties the output register.
// ----------------------------------------------------------------------------
`include "offset_limited_drift_rate_update_defines.svh"

module offset_limited_drift_rate_update #(
  parameter int TIME_BITS  = oldru_pkg::TIME_BITS_DEF,
  parameter int DRIFT_BITS = oldru_pkg::DRIFT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  oldru_in_if.sink                            in_ch,
  oldru_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [oldru_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [oldru_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AD_W  = (DRIFT_BITS > oldru_pkg::INIT_W) ? DRIFT_BITS
                                                          : oldru_pkg::INIT_W + 1;
  localparam int D_W   = AD_W + 1;
  localparam int CMP_W = oldru_pkg::max_int(TIME_BITS, oldru_pkg::OFFSET_W);
  localparam int LHS_W = 2 * AD_W + oldru_pkg::INTERVAL_W;
  localparam int RHS_W = oldru_pkg::ADJ_W + oldru_pkg::SCALE_W + oldru_pkg::OFFSET_W;
  localparam int P_W   = oldru_pkg::max_int(LHS_W, RHS_W);
  localparam int B_W   = oldru_pkg::max_int(AD_W,
                           oldru_pkg::max_int(oldru_pkg::INTERVAL_W, oldru_pkg::OFFSET_W));

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_LHS  = 3'd3;
  localparam logic [2:0] ST_MA   = 3'd4;
  localparam logic [2:0] ST_RHS  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic signed [D_W-1:0] OUT_LIM_X = D_W'(oldru_pkg::OUT_LIMIT);

  // configuration
  logic        [oldru_pkg::OFFSET_W-1:0]   max_offset_r;
  logic        [oldru_pkg::ADJ_W-1:0]      max_adjust_r;
  logic        [oldru_pkg::INTERVAL_W-1:0] interval_r;
  logic signed [oldru_pkg::INIT_W-1:0]     init_r;
  logic signed [oldru_pkg::LOWER_W-1:0]    lower_r;
  logic        [oldru_pkg::UPPER_W-1:0]    upper_r;

  // state and sequencing
  logic [2:0]                     state_r, state_nxt;
  logic signed [DRIFT_BITS-1:0]   total_r;
  logic signed [DRIFT_BITS-1:0]   total_nxt;

  // per-tick working registers
  logic [TIME_BITS-1:0]                  mag_r;
  logic signed [oldru_pkg::STEP_W-1:0]   step_r;
  logic                                  off_pos_r, off_neg_r;
  logic                                  away_r, neg_room_r, reach_r, corr_r;
  logic [oldru_pkg::OFFSET_W-1:0]        room_r;
  logic [P_W-1:0]                        lhs_r;

  // output register
  logic                                  out_valid_r;
  logic signed [oldru_pkg::OUT_W-1:0]    out_drift_r;
  logic                                  out_corr_r;

  logic                          in_fire, out_free, corr;
  logic [TIME_BITS-1:0]          in_mag;
  logic signed [D_W-1:0]         init_x, total_x, drift, drift_sat;
  logic [D_W-1:0]                drift_abs;
  logic [AD_W-1:0]               ad;
  logic [CMP_W-1:0]              mag_x, mo_x;
  logic                          neg_room, away, skip;
  logic [oldru_pkg::OFFSET_W-1:0] room;

  logic           mul_start, mul_done;
  logic [P_W-1:0] mul_a, mul_prod;
  logic [B_W-1:0] mul_b;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_drift = out_drift_r;
  assign out_ch.corrected = out_corr_r;

  assign in_mag = in_ch.cur_offset[TIME_BITS-1] ? (~in_ch.cur_offset + 1'b1)
                                                : in_ch.cur_offset;

  always_comb begin
    init_x    = {{(D_W-oldru_pkg::INIT_W){init_r[oldru_pkg::INIT_W-1]}}, init_r};
    total_x   = {{(D_W-DRIFT_BITS){total_r[DRIFT_BITS-1]}}, total_r};
    drift     = init_x + total_x;
    drift_abs = drift[D_W-1] ? -drift : drift;
    ad        = drift_abs[AD_W-1:0];
    mag_x     = CMP_W'(mag_r);
    mo_x      = CMP_W'(max_offset_r);
    neg_room  = mag_x > mo_x;
    room      = oldru_pkg::OFFSET_W'(mo_x - mag_x);
    away      = (off_pos_r && drift[D_W-1]) ||
                (off_neg_r && !drift[D_W-1] && (drift != '0));
    skip      = (drift == '0) || away || neg_room;
    corr      = (!away_r && reach_r) || neg_room_r;
    if (drift > OUT_LIM_X) begin
      drift_sat = OUT_LIM_X;
    end else if (drift < -OUT_LIM_X) begin
      drift_sat = -OUT_LIM_X;
    end else begin
      drift_sat = drift;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (skip) begin
          state_nxt = ST_FIN;
        end else begin
          mul_start = 1'b1;
          mul_a     = P_W'(ad);
          mul_b     = B_W'(ad);
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod;
          mul_b     = B_W'(interval_r);
          state_nxt = ST_LHS;
        end
      end
      ST_LHS: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = P_W'(oldru_pkg::PPB_SCALE);
          mul_b     = B_W'(max_adjust_r);
          state_nxt = ST_MA;
        end
      end
      ST_MA: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod;
          mul_b     = B_W'(room_r);
          state_nxt = ST_RHS;
        end
      end
      ST_RHS: begin
        if (mul_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  oldru_mul #(
    .A_W (P_W),
    .B_W (B_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  oldru_upd #(
    .DRIFT_BITS (DRIFT_BITS)
  ) u_upd (
    .total      (total_r),
    .init_drift (init_r),
    .max_adjust (max_adjust_r),
    .lower      (lower_r),
    .upper      (upper_r),
    .step       (step_r),
    .off_pos    (off_pos_r),
    .away       (away_r),
    .corr       (corr),
    .total_nxt  (total_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      max_offset_r <= oldru_pkg::RST_MAX_OFFSET;
      max_adjust_r <= oldru_pkg::RST_MAX_ADJUST;
      interval_r   <= oldru_pkg::RST_CHANGE_INTERVAL;
      init_r       <= oldru_pkg::RST_INITIAL_DRIFT;
      lower_r      <= oldru_pkg::RST_CHANGE_LOWER;
      upper_r      <= oldru_pkg::RST_CHANGE_UPPER;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN) total_r <= total_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          oldru_pkg::REG_MAX_OFFSET:
            max_offset_r <= cfg_wdata[oldru_pkg::OFFSET_W-1:0];
          oldru_pkg::REG_MAX_ADJUST:
            max_adjust_r <= cfg_wdata[oldru_pkg::ADJ_W-1:0];
          oldru_pkg::REG_CHANGE_INTERVAL:
            interval_r <= cfg_wdata[oldru_pkg::INTERVAL_W-1:0];
          oldru_pkg::REG_INITIAL_DRIFT:
            init_r <= cfg_wdata[oldru_pkg::INIT_W-1:0];
          oldru_pkg::REG_CHANGE_LOWER:
            lower_r <= cfg_wdata[oldru_pkg::LOWER_W-1:0];
          oldru_pkg::REG_CHANGE_UPPER:
            upper_r <= cfg_wdata[oldru_pkg::UPPER_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_r     <= in_mag;
      step_r    <= in_ch.random_step;
      off_pos_r <= !in_ch.cur_offset[TIME_BITS-1] && (in_ch.cur_offset != '0);
      off_neg_r <= in_ch.cur_offset[TIME_BITS-1];
    end
    if (state_r == ST_PREP) begin
      away_r     <= away;
      neg_room_r <= neg_room;
      room_r     <= room;
      reach_r    <= 1'b0;
    end
    if (state_r == ST_LHS && mul_done) lhs_r <= mul_prod;
    // drift squared times interval against max_adjust times 1e9 times headroom
    if (state_r == ST_RHS && mul_done) reach_r <= (lhs_r >= mul_prod);
    if (state_r == ST_FIN) corr_r <= corr;
    if (state_r == ST_OUT && out_free) begin
      out_drift_r <= drift_sat[oldru_pkg::OUT_W-1:0];
      out_corr_r  <= corr_r;
    end
  end

  `OLDRU_ASSERT_IMP(a_mul_done_seq, mul_done, (state_r == ST_SQ || state_r == ST_LHS || state_r == ST_MA || state_r == ST_RHS), "multiplier finished outside a product step")
  `OLDRU_ASSERT_NXT(a_out_load, (state_r == ST_OUT && out_free), (out_valid_r && state_r == ST_IDLE), "result beat not loaded")
  `OLDRU_ASSERT_IMP(a_drift_range, out_valid_r, (out_drift_r <= oldru_pkg::OUT_LIMIT && out_drift_r >= -oldru_pkg::OUT_LIMIT), "new drift out of range")

endmodule

// ===== rtl/core/oldru_mul.sv =====
// ----------------------------------------------------------------------------
// oldru_mul
// shared shift-add multiplier, two multiplier bits per cycle, stops early
// once the remaining multiplier bits are zero
// ----------------------------------------------------------------------------
module oldru_mul #(
  parameter int A_W = 90,
  parameter int B_W = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a_in,
  input  logic [B_W-1:0] b_in,
  output logic           done,
  output logic [A_W-1:0] prod
);

  logic           busy_r, busy_nxt;
  logic [A_W-1:0] a_r, a_nxt;
  logic [A_W-1:0] acc_r, acc_nxt;
  logic [B_W-1:0] b_r, b_nxt;
  logic [A_W-1:0] pp0, pp1;
  logic           b_zero;

  assign b_zero = (b_r == '0);
  assign done   = busy_r && b_zero;
  assign prod   = acc_r;

  always_comb begin
    pp0      = b_r[0] ? a_r : '0;
    pp1      = b_r[1] ? {a_r[A_W-2:0], 1'b0} : '0;
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a_in;
      b_nxt    = b_in;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (b_zero) begin
        busy_nxt = 1'b0;
      end else begin
        acc_nxt = acc_r + pp0 + pp1;
        a_nxt   = {a_r[A_W-3:0], 2'b00};
        b_nxt   = {2'b00, b_r[B_W-1:2]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// ===== rtl/core/oldru_upd.sv =====
// ----------------------------------------------------------------------------
// oldru_upd
// next accumulated drift change: corrective step toward zero or clamped
// random walk, saturated to the accumulator range
// ----------------------------------------------------------------------------
module oldru_upd #(
  parameter int DRIFT_BITS = oldru_pkg::DRIFT_BITS_DEF
) (
  input  logic signed [DRIFT_BITS-1:0]          total,
  input  logic signed [oldru_pkg::INIT_W-1:0]   init_drift,
  input  logic        [oldru_pkg::ADJ_W-1:0]    max_adjust,
  input  logic signed [oldru_pkg::LOWER_W-1:0]  lower,
  input  logic        [oldru_pkg::UPPER_W-1:0]  upper,
  input  logic signed [oldru_pkg::STEP_W-1:0]   step,
  input  logic                                  off_pos,
  input  logic                                  away,
  input  logic                                  corr,
  output logic signed [DRIFT_BITS-1:0]          total_nxt
);

  localparam int T_W = oldru_pkg::max_int(DRIFT_BITS, oldru_pkg::LOWER_W) + 3;
  localparam logic signed [T_W-1:0] SAT_HI = (T_W'(1) <<< (DRIFT_BITS - 1)) - T_W'(1);
  localparam logic signed [T_W-1:0] SAT_LO = -SAT_HI - T_W'(1);

  logic signed [T_W-1:0] total_x, init_x, step_x, lower_x, upper_x, ma_x;
  logic signed [T_W-1:0] adj, t_corr, t_walk0, t_walk1, t_walk, t_sel, t_sat;

  assign total_x = {{(T_W-DRIFT_BITS){total[DRIFT_BITS-1]}}, total};
  assign init_x  = {{(T_W-oldru_pkg::INIT_W){init_drift[oldru_pkg::INIT_W-1]}}, init_drift};
  assign step_x  = {{(T_W-oldru_pkg::STEP_W){step[oldru_pkg::STEP_W-1]}}, step};
  assign lower_x = {{(T_W-oldru_pkg::LOWER_W){lower[oldru_pkg::LOWER_W-1]}}, lower};
  assign upper_x = {{(T_W-oldru_pkg::UPPER_W){1'b0}}, upper};
  assign ma_x    = {{(T_W-oldru_pkg::ADJ_W){1'b0}}, max_adjust};

  always_comb begin
    adj     = off_pos ? -ma_x : ma_x;
    // moving away means the stepped drift would overshoot adj
    t_corr  = away ? (adj - init_x) : (total_x + adj);
    t_walk0 = total_x + step_x;
    t_walk1 = (t_walk0 < lower_x) ? lower_x : t_walk0;
    t_walk  = (t_walk1 > upper_x) ? upper_x : t_walk1;
    t_sel   = corr ? t_corr : t_walk;
    if (t_sel > SAT_HI) begin
      t_sat = SAT_HI;
    end else if (t_sel < SAT_LO) begin
      t_sat = SAT_LO;
    end else begin
      t_sat = t_sel;
    end
    total_nxt = t_sat[DRIFT_BITS-1:0];
  end

endmodule

// ===== test/oldru_drift_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oldru_drift_checker
// Watches the tick and result channels and the register port of the drift
// update block, works out the drift rate each tick must give, and compares
// every result beat field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module oldru_drift_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  oldru_in_if                               in_ch,
  oldru_out_if                              out_ch,
  input  logic                              cfg_we,
  input  logic [oldru_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [oldru_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                fail_cnt,
  output int                                pending_cnt
);

  typedef struct packed {
    logic signed [oldru_pkg::OUT_W-1:0] new_drift;
    logic                               corrected;
  } drift_beat_t;

  logic        [oldru_pkg::OFFSET_W-1:0]         lim_offset;
  logic        [oldru_pkg::ADJ_W-1:0]            step_adjust;
  logic        [oldru_pkg::INTERVAL_W-1:0]       tick_interval;
  logic signed [oldru_pkg::INIT_W-1:0]           drift_init;
  logic signed [oldru_pkg::LOWER_W-1:0]          total_lo;
  logic        [oldru_pkg::UPPER_W-1:0]          total_hi;
  logic signed [oldru_pkg::DRIFT_BITS_DEF-1:0]   drift_total;

  drift_beat_t drift_expect_q[$];
  int          fails;

  function automatic drift_beat_t next_drift(
    input logic signed [oldru_pkg::TIME_BITS_DEF-1:0] offset,
    input logic signed [oldru_pkg::STEP_W-1:0]        step);
    longint      off, d, ad, mag, mo, room, adj, t, nd, sat_hi;
    logic [127:0] need, avail;
    logic        past, away, reach;
    drift_beat_t beat;
    off   = offset;
    d     = longint'(drift_init) + longint'(drift_total);
    mag   = (off < 0) ? -off : off;
    mo    = longint'(lim_offset);
    past  = mag > mo;
    room  = past ? 0 : mo - mag;
    away  = (off > 0 && d < 0) || (off < 0 && d > 0);
    reach = 1'b0;
    // zero drift never runs into the limit
    if (d != 0) begin
      ad    = (d < 0) ? -d : d;
      need  = 128'(ad * ad) * 128'(tick_interval);
      avail = 128'(longint'(step_adjust) * longint'(oldru_pkg::PPB_SCALE)) * 128'(room);
      reach = need >= avail;
    end
    if (past || (!away && reach)) begin
      adj = (off > 0) ? -longint'(step_adjust) : longint'(step_adjust);
      t   = longint'(drift_total) + adj;
      nd  = longint'(drift_init) + t;
      if ((off > 0 && nd < adj) || (off < 0 && nd > adj)) begin
        t = adj - longint'(drift_init);
      end
      beat.corrected = 1'b1;
    end else begin
      t = longint'(drift_total) + longint'(step);
      if (t < longint'(total_lo)) t = longint'(total_lo);
      if (t > longint'(total_hi)) t = longint'(total_hi);
      beat.corrected = 1'b0;
    end
    sat_hi = (longint'(1) <<< (oldru_pkg::DRIFT_BITS_DEF - 1)) - 1;
    if (t > sat_hi) t = sat_hi;
    if (t < -sat_hi - 1) t = -sat_hi - 1;
    drift_total = oldru_pkg::DRIFT_BITS_DEF'(t);
    nd = longint'(drift_init) + t;
    if (nd > longint'(oldru_pkg::OUT_LIMIT)) nd = longint'(oldru_pkg::OUT_LIMIT);
    if (nd < -longint'(oldru_pkg::OUT_LIMIT)) nd = -longint'(oldru_pkg::OUT_LIMIT);
    beat.new_drift = oldru_pkg::OUT_W'(nd);
    return beat;
  endfunction

  always @(posedge clk) begin
    drift_beat_t want;
    if (!rst_n) begin
      lim_offset    = oldru_pkg::RST_MAX_OFFSET;
      step_adjust   = oldru_pkg::RST_MAX_ADJUST;
      tick_interval = oldru_pkg::RST_CHANGE_INTERVAL;
      drift_init    = oldru_pkg::RST_INITIAL_DRIFT;
      total_lo      = oldru_pkg::RST_CHANGE_LOWER;
      total_hi      = oldru_pkg::RST_CHANGE_UPPER;
      drift_total   = '0;
      drift_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          oldru_pkg::REG_MAX_OFFSET:
            lim_offset    = cfg_wdata[oldru_pkg::OFFSET_W-1:0];
          oldru_pkg::REG_MAX_ADJUST:
            step_adjust   = cfg_wdata[oldru_pkg::ADJ_W-1:0];
          oldru_pkg::REG_CHANGE_INTERVAL:
            tick_interval = cfg_wdata[oldru_pkg::INTERVAL_W-1:0];
          oldru_pkg::REG_INITIAL_DRIFT:
            drift_init    = cfg_wdata[oldru_pkg::INIT_W-1:0];
          oldru_pkg::REG_CHANGE_LOWER:
            total_lo      = cfg_wdata[oldru_pkg::LOWER_W-1:0];
          oldru_pkg::REG_CHANGE_UPPER:
            total_hi      = cfg_wdata[oldru_pkg::UPPER_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        drift_expect_q.push_back(next_drift(in_ch.cur_offset, in_ch.random_step));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (drift_expect_q.size() == 0) begin
          $display("%0t: result beat with no tick outstanding: expected none, got %0d/%0b",
                   $time, out_ch.new_drift, out_ch.corrected);
          fails++;
        end else begin
          want = drift_expect_q.pop_front();
          if (out_ch.new_drift !== want.new_drift) begin
            $display("%0t: new_drift mismatch: expected %0d, got %0d",
                     $time, want.new_drift, out_ch.new_drift);
            fails++;
          end
          if (out_ch.corrected !== want.corrected) begin
            $display("%0t: corrected mismatch: expected %0b, got %0b",
                     $time, want.corrected, out_ch.corrected);
            fails++;
          end
        end
      end
    end
    fail_cnt    <= fails;
    pending_cnt <= drift_expect_q.size();
  end

endmodule

// ===== test/tb_offset_limited_drift_rate_update.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_offset_limited_drift_rate_update
// Drives change ticks in bursts through several register settings, from a
// directed opening to long random runs, with a stalling receiver; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_offset_limited_drift_rate_update;

  localparam int     RUN_LIMIT    = 1000000;
  localparam int     LONG_HOLD    = 400;
  localparam int     DRAIN_TAIL   = 100;
  localparam int     NUM_PHASES   = 12;
  localparam int     PHASE_ITEMS  = 120;
  localparam longint OFFSET_TOP   = 64'sd140737488355327;
  localparam longint OFFSET_BOT   = -64'sd140737488355328;
  localparam longint REG40_MAX    = 64'sd1099511627775;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [oldru_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [oldru_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                               hold_req;
  int                               fail_cnt;
  int                               pending_cnt;
  int                               cycle_cnt;
  longint                           stim_max_offset;

  oldru_in_if  in_ch ();
  oldru_out_if out_ch ();

  offset_limited_drift_rate_update uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  oldru_drift_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: segments of steady, thinned, periodic or heavy stalling
  initial begin
    int mode, seg, k, n, h, hold_done;
    out_ch.ready = 1'b0;
    hold_done    = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(5, 80);
      k    = $urandom_range(2, 5);
      for (n = 0; n < seg; n++) begin
        @(posedge clk);
        if (hold_req != hold_done) begin
          hold_done    = hold_req;
          out_ch.ready <= 1'b0;
          for (h = 1; h < LONG_HOLD; h++) @(posedge clk);
        end else begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       out_ch.ready <= ((n % k) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic send_tick(input longint offset, input int step);
    in_ch.valid       <= 1'b1;
    in_ch.cur_offset  <= oldru_pkg::TIME_BITS_DEF'(offset);
    in_ch.random_step <= oldru_pkg::STEP_W'(step);
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0 || in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [oldru_pkg::CFG_IDX_W-1:0] idx, input longint val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= oldru_pkg::CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic load_setting(input longint mo, input longint ma, input longint ci,
                              input longint init, input longint lo, input longint hi);
    write_reg(oldru_pkg::REG_MAX_OFFSET, mo);
    write_reg(oldru_pkg::REG_MAX_ADJUST, ma);
    write_reg(oldru_pkg::REG_CHANGE_INTERVAL, ci);
    write_reg(oldru_pkg::REG_INITIAL_DRIFT, init);
    write_reg(oldru_pkg::REG_CHANGE_LOWER, lo);
    write_reg(oldru_pkg::REG_CHANGE_UPPER, hi);
    cfg_we <= 1'b0;
    stim_max_offset = mo;
  endtask

  task automatic pick_setting(input int phase);
    longint mo, ma, ci, init, lo, hi;
    case (phase)
      0: load_setting(0, 1, 1, -1000000, -2000000, 0);
      1: load_setting(REG40_MAX, 1000000, REG40_MAX, 1000000, 0, 2000000);
      2: load_setting(1000000, 1000, 1000000000, 0, -100000, 100000);
      default: begin
        case ($urandom_range(0, 5))
          0:       mo = 0;
          1:       mo = REG40_MAX;
          2:       mo = $urandom_range(1, 100);
          default: mo = $urandom_range(1000, 50000000);
        endcase
        case ($urandom_range(0, 3))
          0:       ma = 1;
          1:       ma = 1000000;
          2:       ma = $urandom_range(1, 1000000);
          default: ma = $urandom_range(1, 20000);
        endcase
        case ($urandom_range(0, 4))
          0:       ci = 1;
          1:       ci = REG40_MAX;
          2:       ci = longint'({$urandom, $urandom}) & REG40_MAX;
          default: ci = $urandom_range(1000000, 2000000000);
        endcase
        if (ci == 0) ci = 1;
        case ($urandom_range(0, 4))
          0:       init = -1000000;
          1:       init = 1000000;
          2:       init = 0;
          default: init = longint'($urandom_range(0, 2000000)) - 1000000;
        endcase
        case ($urandom_range(0, 3))
          0:       lo = -2000000;
          1:       lo = 0;
          default: lo = -longint'($urandom_range(0, 2000000));
        endcase
        case ($urandom_range(0, 3))
          0:       hi = 0;
          1:       hi = 2000000;
          default: hi = $urandom_range(0, 2000000);
        endcase
        load_setting(mo, ma, ci, init, lo, hi);
      end
    endcase
  endtask

  function automatic longint pick_offset();
    longint span, v;
    span = stim_max_offset + stim_max_offset / 4 + 2;
    case ($urandom_range(0, 15))
      0:       v = 0;
      1, 2:    v = longint'({$urandom, $urandom});
      3, 4:    v = stim_max_offset + longint'($urandom_range(0, 2)) - 1;
      5:       v = longint'($urandom_range(0, 2000)) - 1000;
      default: v = longint'({$urandom, $urandom} % span);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic int pick_step();
    int s;
    case ($urandom_range(0, 9))
      0:       s = 1000000;
      1:       s = -1000000;
      2, 3:    s = int'($urandom_range(0, 10000)) - 5000;
      default: s = int'($urandom_range(0, 2000000)) - 1000000;
    endcase
    return s;
  endfunction

  initial begin
    int p, i, b, burst;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cur_offset  = '0;
    in_ch.random_step = '0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    hold_req          = 0;
    stim_max_offset   = oldru_pkg::RST_MAX_OFFSET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: random walk, limits, corrective steps and clamps
    send_tick(0, 0);
    send_tick(0, 1000000);
    send_tick(0, -1000000);
    send_tick(OFFSET_TOP, 0);
    send_tick(OFFSET_BOT, 0);
    send_tick(500000, 50000);
    send_tick(-500000, 0);
    send_tick(999000, 0);
    send_tick(1000000, 0);
    send_tick(1000001, 0);
    send_tick(-1000001, 0);
    send_tick(0, 0);
    wait_idle();

    // zero offset with no headroom keeps correcting upward into saturation
    load_setting(0, 1000000, 1, 1000000, -2000000, 2000000);
    repeat (9) send_tick(0, 0);
    send_tick(1, 0);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      pick_setting(p);
      i = 0;
      while (i < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        b = 0;
        while (b < burst && i < PHASE_ITEMS) begin
          if (p == 4 && i == 40) hold_req <= hold_req + 1;
          if (p == 7 && i == 60) wait_idle();
          send_tick(pick_offset(), pick_step());
          b++;
          i++;
        end
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 15));
      end
      wait_idle();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== offset_limited_drift_rate_update.f =====
+incdir+rtl/core
rtl/core/oldru_pkg.sv
rtl/core/oldru_in_if.sv
rtl/core/oldru_out_if.sv
rtl/core/oldru_mul.sv
rtl/core/oldru_upd.sv
rtl/core/offset_limited_drift_rate_update.sv
test/oldru_drift_checker.sv
test/tb_offset_limited_drift_rate_update.sv
